// ===== sv/jhss_pkg.sv =====
// Shared types and constants for the JPEG header size scanner.
`timescale 1ns / 1ps

package jhss_pkg;

    // Marker bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOF_LO = 8'hC0;
    localparam logic [7:0] MARK_SOF_HI = 8'hCF;
    localparam logic [7:0] MARK_DHT    = 8'hC4;
    localparam logic [7:0] MARK_JPG    = 8'hC8;
    localparam logic [7:0] MARK_DAC    = 8'hCC;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [7:0] MARK_EOI    = 8'hD9;

    // Result status codes
    localparam logic [2:0] ST_FOUND   = 3'd0;
    localparam logic [2:0] ST_NOSOI   = 3'd1;
    localparam logic [2:0] ST_GARBAGE = 3'd2;
    localparam logic [2:0] ST_SCANEND = 3'd3;
    localparam logic [2:0] ST_BADLEN  = 3'd4;
    localparam logic [2:0] ST_TRUNC   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_stream;
        logic       end_of_data;
    } jhss_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
    } jhss_result_t;

    // Start-of-frame markers: C0..CF except DHT, JPG and DAC
    function automatic logic is_sof(input logic [7:0] m);
        logic in_range;
        in_range = (m inside {[MARK_SOF_LO:MARK_SOF_HI]});
        return in_range && (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
    endfunction

endpackage

// ===== sv/jhss_chan_if.sv =====
// Valid/ready channel interfaces for scanner input bytes and results.
`timescale 1ns / 1ps

interface jhss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_stream;
    logic       end_of_data;

    modport source (output valid, data_byte, start_of_stream, end_of_data, input ready);
    modport sink   (input valid, data_byte, start_of_stream, end_of_data, output ready);
endinterface

interface jhss_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] frame_width;
    logic [15:0] frame_height;

    modport source (output valid, status, frame_width, frame_height, input ready);
    modport sink   (input valid, status, frame_width, frame_height, output ready);
endinterface

// ===== sv/jhss_parser.sv =====
// Marker parser state and per-byte next-state logic.
`timescale 1ns / 1ps

module jhss_parser
    import jhss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  jhss_item_t   item,
    output logic         hit,
    output jhss_result_t res
);

    typedef enum logic [14:0] {
        PH_SOI1    = 15'h0001,
        PH_SOI2    = 15'h0002,
        PH_FIND    = 15'h0004,
        PH_MARK    = 15'h0008,
        PH_FLEN_HI = 15'h0010,
        PH_FLEN_LO = 15'h0020,
        PH_PREC    = 15'h0040,
        PH_H_HI    = 15'h0080,
        PH_H_LO    = 15'h0100,
        PH_W_HI    = 15'h0200,
        PH_W_LO    = 15'h0400,
        PH_COMP    = 15'h0800,
        PH_SLEN_HI = 15'h1000,
        PH_SLEN_LO = 15'h2000,
        PH_SKIP    = 15'h4000
    } phase_t;

    phase_t      phase_reg,   phase_next,  phase_cur;
    logic        garbage_reg, garbage_next, garbage_cur;
    logic        done_reg,    done_next,    done_cur;
    logic [15:0] skip_reg,    skip_next,    skip_dec;
    logic [7:0]  hi_reg,      hi_next;
    logic [15:0] height_reg,  height_next;
    logic [15:0] width_reg,   width_next;
    logic [15:0] seg_len;
    logic [7:0]  b;

    assign b        = item.data_byte;
    assign seg_len  = {hi_reg, b};
    assign skip_dec = (skip_reg != 16'd0) ? (skip_reg - 16'd1) : skip_reg;

    always_comb
    begin
        // start flag restarts the parser before the byte is looked at
        phase_cur   = item.start_of_stream ? PH_SOI1 : phase_reg;
        garbage_cur = item.start_of_stream ? 1'b0 : garbage_reg;
        done_cur    = item.start_of_stream ? 1'b0 : done_reg;

        phase_next   = phase_cur;
        garbage_next = garbage_cur;
        done_next    = done_cur;
        skip_next    = skip_reg;
        hi_next      = hi_reg;
        height_next  = height_reg;
        width_next   = width_reg;
        hit          = 1'b0;
        res          = '{status: ST_FOUND, frame_width: 16'd0, frame_height: 16'd0};

        if (done_cur)
        begin
            // idle until next stream
        end
        else if (item.end_of_data)
        begin
            hit = 1'b1;
            res.status = ((phase_cur == PH_SOI1) || (phase_cur == PH_SOI2)) ?
                         ST_NOSOI : ST_TRUNC;
        end
        else
        begin
            case (phase_cur)
                PH_SOI1:
                begin
                    if (b != MARK_PREFIX)
                    begin
                        hit = 1'b1;
                        res.status = ST_NOSOI;
                    end
                    else
                        phase_next = PH_SOI2;
                end
                PH_SOI2:
                begin
                    if (b != MARK_SOI)
                    begin
                        hit = 1'b1;
                        res.status = ST_NOSOI;
                    end
                    else
                    begin
                        phase_next   = PH_FIND;
                        garbage_next = 1'b0;
                    end
                end
                PH_FIND:
                begin
                    if (b == MARK_PREFIX)
                        phase_next = PH_MARK;
                    else
                        garbage_next = 1'b1;
                end
                PH_MARK:
                begin
                    if (b == MARK_PREFIX)
                        phase_next = PH_MARK;   // fill byte
                    else if (garbage_cur)
                    begin
                        hit = 1'b1;
                        res.status = ST_GARBAGE;
                    end
                    else if (is_sof(b))
                        phase_next = PH_FLEN_HI;
                    else if ((b == MARK_SOS) || (b == MARK_EOI))
                    begin
                        hit = 1'b1;
                        res.status = ST_SCANEND;
                    end
                    else
                        phase_next = PH_SLEN_HI;
                end
                PH_FLEN_HI: phase_next = PH_FLEN_LO;
                PH_FLEN_LO: phase_next = PH_PREC;
                PH_PREC:    phase_next = PH_H_HI;
                PH_H_HI:
                begin
                    hi_next    = b;
                    phase_next = PH_H_LO;
                end
                PH_H_LO:
                begin
                    height_next = seg_len;
                    phase_next  = PH_W_HI;
                end
                PH_W_HI:
                begin
                    hi_next    = b;
                    phase_next = PH_W_LO;
                end
                PH_W_LO:
                begin
                    width_next = seg_len;
                    phase_next = PH_COMP;
                end
                PH_COMP:
                begin
                    hit = 1'b1;
                    res = '{status: ST_FOUND, frame_width: width_reg,
                            frame_height: height_reg};
                end
                PH_SLEN_HI:
                begin
                    hi_next    = b;
                    phase_next = PH_SLEN_LO;
                end
                PH_SLEN_LO:
                begin
                    if (seg_len < 16'd2)
                    begin
                        hit = 1'b1;
                        res.status = ST_BADLEN;
                    end
                    else
                    begin
                        skip_next    = seg_len - 16'd2;
                        garbage_next = 1'b0;
                        phase_next   = (seg_len == 16'd2) ? PH_FIND : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        garbage_next = 1'b0;
                        phase_next   = PH_FIND;
                    end
                end
                default: phase_next = PH_SOI1;
            endcase
        end

        if (hit)
            done_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SOI1;
            garbage_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            garbage_reg <= garbage_next;
            done_reg    <= done_next;
        end
    end

    // field holds: always written before being read within a stream
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            skip_reg   <= skip_next;
            hi_reg     <= hi_next;
            height_reg <= height_next;
            width_reg  <= width_next;
        end
    end

endmodule

// ===== sv/jpeg_header_size_scanner_core.sv =====
// Top level of the JPEG header size scanner.
// Takes a JPEG file one byte per request on "item" and returns one result per
// stream on "result": status, frame width and frame height from the first
// start-of-frame header. The stream must open with FF D8; other segments are
// skipped by their length field; garbage before a marker, a scan or end
// marker, a length below two or an early end of data each end the scan with
// their own status. After a result the block drops everything until a byte
// flagged start_of_stream. Throughput is one byte per clock while the sink
// takes results: the byte lands in an input register, then the parser updates
// its phase and counter as any result is loaded into the output register.
// While a result waits on a stalled sink, one further byte is held in the
// input register; the sink's ready feeds straight through to item.ready. Out
// of reset the parser expects the start marker as if a stream had just begun.
`timescale 1ns / 1ps

module jpeg_header_size_scanner_core
    import jhss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    jhss_in_if.sink           item,
    jhss_out_if.source        result
);

    logic         in_valid_reg;
    jhss_item_t   in_reg;
    logic         out_valid_reg;
    jhss_result_t out_reg;

    logic         advance;
    logic         step;
    logic         hit;
    jhss_result_t res;

    // the input stage moves on whenever the output register is free or draining
    assign advance    = !out_valid_reg || result.ready;
    assign step       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
            in_reg <= '{data_byte: item.data_byte,
                        start_of_stream: item.start_of_stream,
                        end_of_data: item.end_of_data};
    end

    jhss_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_reg),
        .hit   (hit),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step && hit;
    end

    always_ff @(posedge clk)
    begin
        if (step && hit)
            out_reg <= res;
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_reg.status;
    assign result.frame_width  = out_reg.frame_width;
    assign result.frame_height = out_reg.frame_height;

endmodule

// ===== sv/jhss_checker.sv =====
// Port-level assertions for the JPEG header size scanner, bound to the top level.
`timescale 1ns / 1ps

module jhss_checker
    import jhss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_status,
    input logic [15:0] out_width,
    input logic [15:0] out_height
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
            && $stable(out_width) && $stable(out_height))
        else $error("result changed while stalled");

    // dimensions only on a found frame
    a_dims_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != ST_FOUND) |-> (out_width == 16'd0)
            && (out_height == 16'd0))
        else $error("nonzero dimensions on failure status");

    // a fresh result traces back to an accepted byte, through the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching request");

    // an empty output stage never blocks input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind jpeg_header_size_scanner_core jhss_checker u_jhss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_status (result.status),
    .out_width  (result.frame_width),
    .out_height (result.frame_height)
);

// ===== sim/tb_jpeg_header_size_scanner_core.sv =====
// Self-checking testbench for the JPEG header size scanner core.
`timescale 1ns / 1ps

module tb_jpeg_header_size_scanner_core;
    import jhss_pkg::*;

    // Random part stops once this many bytes have reached the parser
    // (bytes dropped after a result do not count).
    localparam int ITEM_TARGET  = 1650;
    // The limit lies far above the slowest legal run: ~2.5k requests with
    // 22% source gaps, ~150 results each waiting out a sink stall, one
    // HOLDOFF_LEN hold-off.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLDOFF_LEN  = 300;
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 550;
    localparam int HOLDOFF_AT   = 900;

    // Parser position within the header, kept by the predictor.
    typedef enum logic [3:0] {
        P_SOI1, P_SOI2, P_FIND, P_MARK,
        P_FLEN_HI, P_FLEN_LO, P_PREC,
        P_HGT_HI, P_HGT_LO, P_WID_HI, P_WID_LO, P_COMP,
        P_SLEN_HI, P_SLEN_LO, P_SKIP
    } scan_phase_e;

    // Tracks the header parse for every accepted request and holds the
    // frame dimensions (or error status) that the block has yet to report.
    class frame_dim_tracker;
        scan_phase_e  phase;
        bit           garbage;
        bit           done;
        logic [15:0]  skip_left;
        logic [7:0]   hi_byte;
        logic [15:0]  height;
        logic [15:0]  width;
        jhss_result_t expected_dims[$];
        int           errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase     = P_SOI1;
            garbage   = 1'b0;
            done      = 1'b0;
            skip_left = '0;
            hi_byte   = '0;
            height    = '0;
            width     = '0;
        endfunction

        static function bit sof_marker(logic [7:0] m);
            return (m[7:4] == MARK_SOF_LO[7:4]) && (m != MARK_DHT) &&
                   (m != MARK_JPG) && (m != MARK_DAC);
        endfunction

        // Returns 1 when the byte reached the parser, 0 when it was dropped.
        function bit take_request(jhss_item_t req);
            logic [7:0]   b;
            logic [15:0]  seg_len;
            logic [2:0]   st;
            bit           hit;
            jhss_result_t r;
            b   = req.data_byte;
            hit = 1'b0;
            st  = ST_FOUND;
            if (req.start_of_stream)
                restart();
            if (done)
                return 1'b0;
            if (req.end_of_data)
            begin
                hit = 1'b1;
                st  = (phase == P_SOI1 || phase == P_SOI2) ? ST_NOSOI : ST_TRUNC;
            end
            else
            begin
                case (phase)
                    P_SOI1:
                        if (b != MARK_PREFIX)
                        begin
                            hit = 1'b1;
                            st  = ST_NOSOI;
                        end
                        else
                            phase = P_SOI2;
                    P_SOI2:
                        if (b != MARK_SOI)
                        begin
                            hit = 1'b1;
                            st  = ST_NOSOI;
                        end
                        else
                        begin
                            phase   = P_FIND;
                            garbage = 1'b0;
                        end
                    P_FIND:
                        if (b == MARK_PREFIX)
                            phase = P_MARK;
                        else
                            garbage = 1'b1;
                    P_MARK:
                        if (b == MARK_PREFIX)
                            phase = P_MARK;
                        else if (garbage)
                        begin
                            hit = 1'b1;
                            st  = ST_GARBAGE;
                        end
                        else if (sof_marker(b))
                            phase = P_FLEN_HI;
                        else if (b == MARK_SOS || b == MARK_EOI)
                        begin
                            hit = 1'b1;
                            st  = ST_SCANEND;
                        end
                        else
                            phase = P_SLEN_HI;
                    P_FLEN_HI: phase = P_FLEN_LO;
                    P_FLEN_LO: phase = P_PREC;
                    P_PREC:    phase = P_HGT_HI;
                    P_HGT_HI:
                    begin
                        hi_byte = b;
                        phase   = P_HGT_LO;
                    end
                    P_HGT_LO:
                    begin
                        height = {hi_byte, b};
                        phase  = P_WID_HI;
                    end
                    P_WID_HI:
                    begin
                        hi_byte = b;
                        phase   = P_WID_LO;
                    end
                    P_WID_LO:
                    begin
                        width = {hi_byte, b};
                        phase = P_COMP;
                    end
                    P_COMP:
                    begin
                        hit = 1'b1;
                        st  = ST_FOUND;
                    end
                    P_SLEN_HI:
                    begin
                        hi_byte = b;
                        phase   = P_SLEN_LO;
                    end
                    P_SLEN_LO:
                    begin
                        seg_len = {hi_byte, b};
                        if (seg_len < 16'd2)
                        begin
                            hit = 1'b1;
                            st  = ST_BADLEN;
                        end
                        else
                        begin
                            skip_left = seg_len - 16'd2;
                            garbage   = 1'b0;
                            phase     = (skip_left == 16'd0) ? P_FIND : P_SKIP;
                        end
                    end
                    P_SKIP:
                    begin
                        if (skip_left != 16'd0)
                            skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0)
                        begin
                            garbage = 1'b0;
                            phase   = P_FIND;
                        end
                    end
                    default: phase = P_SOI1;
                endcase
            end
            if (hit)
            begin
                r.status       = st;
                r.frame_width  = (st == ST_FOUND) ? width : 16'd0;
                r.frame_height = (st == ST_FOUND) ? height : 16'd0;
                expected_dims.push_back(r);
                done = 1'b1;
            end
            return 1'b1;
        endfunction

        function void match_result(jhss_result_t got);
            jhss_result_t want;
            if (expected_dims.size() == 0)
            begin
                $error("unexpected result: status %0d width %0d height %0d",
                       got.status, got.frame_width, got.frame_height);
                errors++;
                return;
            end
            want = expected_dims.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.frame_width !== want.frame_width)
            begin
                $error("frame_width: expected %0d, actual %0d",
                       want.frame_width, got.frame_width);
                errors++;
            end
            if (got.frame_height !== want.frame_height)
            begin
                $error("frame_height: expected %0d, actual %0d",
                       want.frame_height, got.frame_height);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    jhss_in_if  item_if ();
    jhss_out_if result_if ();

    jpeg_header_size_scanner_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    frame_dim_tracker dims = new();

    jhss_item_t  stream_q[$];      // bytes of the file being built
    int          bytes_parsed = 0; // requests that reached the parser
    bit          calm = 1'b0;      // no idling on either side
    bit          holdoff_fired = 1'b0;
    int          holdoff_cycles = 0;
    int unsigned cycle_count = 0;

    always #10 clk = ~clk;

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result sink: random stalls, a calm stretch, and one long hold-off that
    // it counts down itself while the source keeps pushing bytes.
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_cycles > 0)
            begin
                holdoff_cycles--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= calm || ($urandom_range(0, 99) >= 22);
        end
    end

    // Every accepted result is checked against the oldest expected one.
    always @(posedge clk)
        if (rst_n && result_if.valid && result_if.ready)
            dims.match_result({result_if.status, result_if.frame_width,
                               result_if.frame_height});

    // One request on the byte channel; the predictor sees it at the edge
    // where it is accepted. Valid stays high straight into the next request
    // when no gap is drawn, so it gets one assignment per edge.
    task automatic send_request(jhss_item_t req);
        int gap;
        gap = 0;
        if (!calm && holdoff_cycles == 0)
            while ($urandom_range(0, 99) < 22)
                gap++;
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid           <= 1'b1;
        item_if.data_byte       <= req.data_byte;
        item_if.start_of_stream <= req.start_of_stream;
        item_if.end_of_data     <= req.end_of_data;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        if (dims.take_request(req))
            bytes_parsed++;
        calm = (bytes_parsed >= CALM_FROM) && (bytes_parsed < CALM_TO);
        if (!holdoff_fired && bytes_parsed >= HOLDOFF_AT)
        begin
            holdoff_fired  = 1'b1;
            holdoff_cycles = HOLDOFF_LEN;
        end
    endtask

    task automatic put(logic [7:0] b, bit sos = 1'b0, bit eod = 1'b0);
        jhss_item_t req;
        req.data_byte       = b;
        req.start_of_stream = sos;
        req.end_of_data     = eod;
        send_request(req);
    endtask

    // --- file builders ---

    task automatic push_byte(logic [7:0] b, bit sos = 1'b0, bit eod = 1'b0);
        jhss_item_t req;
        req.data_byte       = b;
        req.start_of_stream = sos;
        req.end_of_data     = eod;
        stream_q.push_back(req);
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Any marker that opens a skippable segment.
    function automatic logic [7:0] pick_plain_marker();
        logic [7:0] m;
        do
            m = 8'($urandom_range(0, 254));
        while (frame_dim_tracker::sof_marker(m) || m == MARK_SOS || m == MARK_EOI);
        return m;
    endfunction

    task automatic add_marker(logic [7:0] m);
        push_byte(MARK_PREFIX);
        // occasional fill bytes ahead of the marker code
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(MARK_PREFIX);
        push_byte(m);
    endtask

    task automatic add_segment();
        logic [15:0] seg_len;
        // mostly short, now and then long enough to use the counter's high byte
        seg_len = ($urandom_range(0, 49) == 0) ? 16'($urandom_range(256, 300))
                                               : 16'($urandom_range(2, 12));
        add_marker(pick_plain_marker());
        push_byte(seg_len[15:8]);
        push_byte(seg_len[7:0]);
        repeat (seg_len - 16'd2) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_frame();
        logic [7:0]  m;
        logic [15:0] h;
        logic [15:0] w;
        do
            m = MARK_SOF_LO | 8'($urandom_range(0, 15));
        while (!frame_dim_tracker::sof_marker(m));
        h = pick_dim();
        w = pick_dim();
        add_marker(m);
        push_byte(8'($urandom_range(0, 255)));   // length, not checked
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));   // precision
        push_byte(h[15:8]);
        push_byte(h[7:0]);
        push_byte(w[15:8]);
        push_byte(w[7:0]);
        push_byte(8'($urandom_range(0, 255)));   // component count
    endtask

    task automatic add_soi();
        push_byte(MARK_PREFIX, 1'b1);
        push_byte(MARK_SOI);
    endtask

    // One file: mostly well-formed headers with random content, the rest
    // broken in each of the ways the scanner reports.
    task automatic build_stream();
        int         kind;
        int         cut;
        logic [7:0] first;
        stream_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 62)
        begin
            add_soi();
            repeat ($urandom_range(0, 3)) add_segment();
            add_frame();
            // trailing bytes are dropped after the result
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0)
                push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            // cut short: either an end flag or the next file's start flag
            if ($urandom_range(0, 99) < 15)
            begin
                cut = $urandom_range(1, stream_q.size() - 1);
                while (stream_q.size() > cut)
                    void'(stream_q.pop_back());
                if ($urandom_range(0, 3) != 0)
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
        else if (kind < 72)
        begin
            // stray bytes before a marker
            add_soi();
            if ($urandom_range(0, 1) == 0)
                add_segment();
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 254)));
            push_byte(MARK_PREFIX);
            push_byte(8'($urandom_range(0, 254)));
        end
        else if (kind < 80)
        begin
            add_soi();
            repeat ($urandom_range(0, 2)) add_segment();
            add_marker($urandom_range(0, 1) ? MARK_SOS : MARK_EOI);
        end
        else if (kind < 87)
        begin
            add_soi();
            repeat ($urandom_range(0, 1)) add_segment();
            add_marker(pick_plain_marker());
            push_byte(8'h00);
            push_byte(8'($urandom_range(0, 1)));
        end
        else if (kind < 94)
        begin
            // bad start marker
            first = 8'($urandom_range(0, 255));
            push_byte(first, 1'b1);
            if (first == MARK_PREFIX)
            begin
                do
                    first = 8'($urandom_range(0, 255));
                while (first == MARK_SOI);
                push_byte(first);
            end
        end
        else
        begin
            // noise, with end flags now and then
            push_byte(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 6))
                push_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 7) == 0);
        end
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        item_if.valid           <= 1'b0;
        item_if.data_byte       <= 8'h00;
        item_if.start_of_stream <= 1'b0;
        item_if.end_of_data     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Parser is live out of reset: no start flag on the first file,
        // which ends on a scan marker.
        put(MARK_PREFIX);
        put(MARK_SOI);
        put(MARK_PREFIX);
        put(MARK_SOS);
        // start and end flag together: empty file, no start marker
        put(8'h00, 1'b1, 1'b1);
        // file ends inside the start marker
        put(MARK_PREFIX, 1'b1);
        put(8'h00, 1'b0, 1'b1);
        // wrong first byte
        put(8'h00, 1'b1);
        // file ends after the start marker: truncated
        put(MARK_PREFIX, 1'b1);
        put(MARK_SOI);
        put(8'hA5, 1'b0, 1'b1);
        // garbage before the marker, reported whatever the marker is
        put(MARK_PREFIX, 1'b1);
        put(MARK_SOI);
        put(8'h01);
        put(MARK_PREFIX);
        put(MARK_DHT);
        // frame header behind a fill byte, extreme dimensions
        put(MARK_PREFIX, 1'b1);
        put(MARK_SOI);
        put(MARK_PREFIX);
        put(MARK_PREFIX);
        put(MARK_SOF_HI);
        put(8'h00);
        put(8'h11);
        put(8'h08);
        put(8'hFF);
        put(8'hFF);
        put(8'h00);
        put(8'h00);
        put(8'h03);

        while (bytes_parsed < ITEM_TARGET)
        begin
            build_stream();
            foreach (stream_q[i])
                send_request(stream_q[i]);
        end
        item_if.valid <= 1'b0;

        while (dims.expected_dims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (dims.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
